### rtl/tuner_frequency_to_synth_settings_assert.svh
// Assertion macros shared by the checker of the tuner synthesizer block.
// Depends on nothing; included by the checker file.
`ifndef TUNER_FREQUENCY_TO_SYNTH_SETTINGS_ASSERT_SVH
`define TUNER_FREQUENCY_TO_SYNTH_SETTINGS_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define TFS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("tuner synth settings check failed");

// Next-cycle implication, disabled while reset is asserted
`define TFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("tuner synth settings check failed");

`endif

### rtl/tfs_pkg.sv
// Shared types, constants and lookup tables of the tuner synthesizer block.
// Depends on nothing; used by every RTL module of the block.
package tfs_pkg;

	// Field widths
	localparam int unsigned FREQ_W     = 32;
	localparam int unsigned REG_W      = 8;
	localparam int unsigned CH_W       = 5;
	localparam int unsigned BAND_IDX_W = 3;
	localparam int unsigned FDIV_W     = 29;
	localparam int unsigned QUOT_W     = 21;
	localparam int unsigned RES_W      = 13;
	localparam int unsigned STEP_W     = 12;
	localparam int unsigned FRAC_W     = 22;
	localparam int unsigned ADDR_W     = 4;
	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned IN_DATA_W  = 32;
	localparam int unsigned OUT_DATA_W = 56;
	localparam int unsigned OUT_USER_W = 2;
	localparam int unsigned NUM_STAGES = 6;

	// Divide by ten: exact for every 32-bit operand
	localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
	localparam int unsigned DIV10_SHIFT = 35;

	// Channel grids
	localparam logic [31:0]       GRID0_BASE  = 32'd104948;
	localparam logic [31:0]       GRID1_BASE  = 32'd161300;
	localparam logic [31:0]       GRID2_BASE  = 32'd159300;
	localparam logic [STEP_W-1:0] GRID0_STEP  = 12'd3836;
	localparam logic [STEP_W-1:0] GRID12_STEP = 12'd4000;
	localparam logic [63:0]       RECIP_ONE   = 64'd1 << 32;
	localparam logic [QUOT_W-1:0] GRID0_RECIP  = QUOT_W'(RECIP_ONE / 64'd3836);
	localparam logic [QUOT_W-1:0] GRID12_RECIP = QUOT_W'(RECIP_ONE / 64'd4000);
	localparam logic [QUOT_W-1:0] GRID1_CH_LIMIT = 21'd12;
	localparam logic [QUOT_W-1:0] NUM_CH         = 21'd24;
	localparam logic [CH_W-1:0]   GRID1_CH_OFFSET = 5'd12;

	// Band lookup
	localparam logic [31:0] BAND_X_OFFSET = 32'd500;
	localparam int unsigned NUM_BANDS     = 8;

	// Kept bits of the prior register values
	localparam logic [REG_W-1:0] KEEP_BAND      = 8'h0f;
	localparam logic [REG_W-1:0] KEEP_DIVIDER   = 8'h40;
	localparam logic [REG_W-1:0] KEEP_SWALLOW   = 8'hf0;
	localparam logic [REG_W-1:0] KEEP_FRAC_HIGH = 8'hc0;

	// Register reset values
	localparam logic [REG_W-1:0] RST_BAND      = 8'd160;
	localparam logic [REG_W-1:0] RST_DIVIDER   = 8'd32;
	localparam logic [REG_W-1:0] RST_SWALLOW   = 8'd51;
	localparam logic [REG_W-1:0] RST_FRAC_HIGH = 8'd0;

	typedef enum logic [1:0] {
		REG_BAND_PRIOR,
		REG_DIVIDER_PRIOR,
		REG_SWALLOW_PRIOR,
		REG_FRAC_HIGH_PRIOR
	} reg_idx_t;

	typedef struct packed {
		logic [REG_W-1:0] band;
		logic [REG_W-1:0] divider;
		logic [REG_W-1:0] swallow;
		logic [REG_W-1:0] frac_high;
	} prior_t;

	// Stage load enables
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic s5;
		logic s6;
	} adv_t;

	// Channel fit result handed to the register merge stage
	typedef struct packed {
		logic                  invalid;
		logic [CH_W-1:0]       ch;
		logic                  band_hit;
		logic [BAND_IDX_W-1:0] band_idx;
	} fit_t;

	// Upper (exclusive) edge of a band range
	function automatic logic [31:0] band_upper(logic [BAND_IDX_W-1:0] idx);
		logic [31:0] e;
		case (idx)
			3'd0:    e = 32'd2151000;
			3'd1:    e = 32'd1950000;
			3'd2:    e = 32'd1800000;
			3'd3:    e = 32'd1600000;
			3'd4:    e = 32'd1450000;
			3'd5:    e = 32'd1250000;
			3'd6:    e = 32'd1200000;
			3'd7:    e = 32'd975000;
			default: e = 32'd0;
		endcase
		return e;
	endfunction

	// Lower (inclusive) edge of a band range
	function automatic logic [31:0] band_lower(logic [BAND_IDX_W-1:0] idx);
		logic [31:0] e;
		case (idx)
			3'd0:    e = 32'd1950000;
			3'd1:    e = 32'd1800000;
			3'd2:    e = 32'd1600000;
			3'd3:    e = 32'd1450000;
			3'd4:    e = 32'd1250000;
			3'd5:    e = 32'd1200000;
			3'd6:    e = 32'd975000;
			3'd7:    e = 32'd950000;
			default: e = 32'd0;
		endcase
		return e;
	endfunction

	// Band bits of register 2: high bit then three select bits
	function automatic logic [3:0] band_bits(logic [BAND_IDX_W-1:0] idx);
		logic [3:0] b;
		case (idx)
			3'd0:    b = {1'b1, 3'd7};
			3'd1:    b = {1'b1, 3'd6};
			3'd2:    b = {1'b1, 3'd5};
			3'd3:    b = {1'b1, 3'd4};
			3'd4:    b = {1'b1, 3'd3};
			3'd5:    b = {1'b1, 3'd2};
			3'd6:    b = {1'b0, 3'd7};
			3'd7:    b = {1'b0, 3'd6};
			default: b = 4'd0;
		endcase
		return b;
	endfunction

	function automatic logic [FRAC_W-1:0] syn_frac(logic [CH_W-1:0] ch);
		logic [FRAC_W-1:0] f;
		case (ch)
			5'd0:    f = 22'h38fae1;
			5'd1:    f = 22'h3f570a;
			5'd2:    f = 22'h05b333;
			5'd3:    f = 22'h3c0f5c;
			5'd4:    f = 22'h026b85;
			5'd5:    f = 22'h38c7ae;
			5'd6:    f = 22'h3f23d7;
			5'd7:    f = 22'h058000;
			5'd8:    f = 22'h3bdc28;
			5'd9:    f = 22'h023851;
			5'd10:   f = 22'h38947a;
			5'd11:   f = 22'h3ef0a3;
			5'd12, 5'd14, 5'd16, 5'd18, 5'd20, 5'd22: f = 22'h3c8000;
			5'd13, 5'd15, 5'd17, 5'd19, 5'd21, 5'd23: f = 22'h048000;
			default: f = '0;
		endcase
		return f;
	endfunction

	function automatic logic [4:0] syn_n(logic [CH_W-1:0] ch);
		logic [4:0] n;
		case (ch)
			5'd0:    n = 5'h0d;
			5'd1:    n = 5'h0e;
			5'd2:    n = 5'h0e;
			5'd3:    n = 5'h0f;
			5'd4:    n = 5'h0f;
			5'd5:    n = 5'h10;
			5'd6:    n = 5'h11;
			5'd7:    n = 5'h11;
			5'd8:    n = 5'h12;
			5'd9:    n = 5'h12;
			5'd10:   n = 5'h13;
			5'd11:   n = 5'h14;
			5'd12:   n = 5'h16;
			5'd13:   n = 5'h16;
			5'd14:   n = 5'h17;
			5'd15:   n = 5'h18;
			5'd16:   n = 5'h18;
			5'd17:   n = 5'h19;
			5'd18:   n = 5'h1a;
			5'd19:   n = 5'h1a;
			5'd20:   n = 5'h1b;
			5'd21:   n = 5'h1b;
			5'd22:   n = 5'h1c;
			5'd23:   n = 5'h1d;
			default: n = '0;
		endcase
		return n;
	endfunction

	function automatic logic [3:0] syn_a(logic [CH_W-1:0] ch);
		logic [3:0] a;
		case (ch)
			5'd0:    a = 4'h5;
			5'd1:    a = 4'h3;
			5'd2:    a = 4'h5;
			5'd3:    a = 4'h4;
			5'd4:    a = 4'h6;
			5'd5:    a = 4'h5;
			5'd6:    a = 4'h3;
			5'd7:    a = 4'h5;
			5'd8:    a = 4'h4;
			5'd9:    a = 4'h6;
			5'd10:   a = 4'h5;
			5'd11:   a = 4'h3;
			5'd12:   a = 4'h4;
			5'd13:   a = 4'h6;
			5'd14:   a = 4'h5;
			5'd15:   a = 4'h3;
			5'd16:   a = 4'h6;
			5'd17:   a = 4'h4;
			5'd18:   a = 4'h3;
			5'd19:   a = 4'h5;
			5'd20:   a = 4'h4;
			5'd21:   a = 4'h6;
			5'd22:   a = 4'h5;
			5'd23:   a = 4'h3;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage

### rtl/tfs_cfg_regs.sv
// APB register file holding the prior values of the synthesizer registers.
// Depends on tfs_pkg.
module tfs_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [tfs_pkg::ADDR_W-1:0]      paddr,
	input  logic [tfs_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [tfs_pkg::APB_DATA_W-1:0]  prdata,
	output logic                            pready,
	output tfs_pkg::prior_t                 prior
);

	tfs_pkg::prior_t  prior_q;
	tfs_pkg::reg_idx_t reg_idx;
	logic             wr_en;

	assign reg_idx = tfs_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;
	assign prior   = prior_q;

	// Write the addressed register on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prior_q.band      <= tfs_pkg::RST_BAND;
			prior_q.divider   <= tfs_pkg::RST_DIVIDER;
			prior_q.swallow   <= tfs_pkg::RST_SWALLOW;
			prior_q.frac_high <= tfs_pkg::RST_FRAC_HIGH;
		end else if (wr_en) begin
			case (reg_idx)
				tfs_pkg::REG_BAND_PRIOR:      prior_q.band      <= pwdata[7:0];
				tfs_pkg::REG_DIVIDER_PRIOR:   prior_q.divider   <= pwdata[7:0];
				tfs_pkg::REG_SWALLOW_PRIOR:   prior_q.swallow   <= pwdata[7:0];
				tfs_pkg::REG_FRAC_HIGH_PRIOR: prior_q.frac_high <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		case (reg_idx)
			tfs_pkg::REG_BAND_PRIOR:      prdata = 32'(prior_q.band);
			tfs_pkg::REG_DIVIDER_PRIOR:   prdata = 32'(prior_q.divider);
			tfs_pkg::REG_SWALLOW_PRIOR:   prdata = 32'(prior_q.swallow);
			tfs_pkg::REG_FRAC_HIGH_PRIOR: prdata = 32'(prior_q.frac_high);
			default:                      prdata = '0;
		endcase
	end

endmodule

### rtl/tfs_channel_fit.sv
// Pipeline stages 1 to 5: divide by ten, fit three channel grids, pick a channel
// and classify the band. Depends on tfs_pkg.
module tfs_channel_fit (
	input  logic                         clk,
	input  tfs_pkg::adv_t                adv,
	input  logic [tfs_pkg::FREQ_W-1:0]   frequency_khz,
	output tfs_pkg::fit_t                fit
);

	// Stage 1: input register
	logic [tfs_pkg::FREQ_W-1:0] khz_s1;

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			khz_s1 <= frequency_khz;
		end
	end

	// Stage 2: divide by ten, band classification
	logic [63:0]                     prod10;
	logic [31:0]                     band_x;
	logic                            band_hit;
	logic [tfs_pkg::BAND_IDX_W-1:0]  band_idx;
	logic [tfs_pkg::FDIV_W-1:0]      f_s2;
	logic                            band_hit_s2;
	logic [tfs_pkg::BAND_IDX_W-1:0]  band_idx_s2;

	assign prod10 = 64'(khz_s1) * 64'(tfs_pkg::DIV10_MAGIC);
	assign band_x = khz_s1 - tfs_pkg::BAND_X_OFFSET;

	// Find the one band range holding the offset frequency
	always_comb begin
		band_hit = 1'b0;
		band_idx = '0;
		for (int i = 0; i < tfs_pkg::NUM_BANDS; i++) begin
			if (band_x >= tfs_pkg::band_lower(3'(i)) &&
			    band_x <  tfs_pkg::band_upper(3'(i))) begin
				band_hit = 1'b1;
				band_idx = 3'(i);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s2) begin
			f_s2        <= prod10[tfs_pkg::DIV10_SHIFT +: tfs_pkg::FDIV_W];
			band_hit_s2 <= band_hit;
			band_idx_s2 <= band_idx;
		end
	end

	// Stage 3: grid offsets and quotient estimates (at most one low)
	logic [31:0]                d0, d1, d2;
	logic [63:0]                qp0, qp1, qp2;
	logic [31:0]                d0_s3, d1_s3, d2_s3;
	logic [tfs_pkg::QUOT_W-1:0] q0_s3, q1_s3, q2_s3;
	logic                           band_hit_s3;
	logic [tfs_pkg::BAND_IDX_W-1:0] band_idx_s3;

	assign d0  = 32'(f_s2) - tfs_pkg::GRID0_BASE;
	assign d1  = 32'(f_s2) - tfs_pkg::GRID1_BASE;
	assign d2  = 32'(f_s2) - tfs_pkg::GRID2_BASE;
	assign qp0 = 64'(d0) * 64'(tfs_pkg::GRID0_RECIP);
	assign qp1 = 64'(d1) * 64'(tfs_pkg::GRID12_RECIP);
	assign qp2 = 64'(d2) * 64'(tfs_pkg::GRID12_RECIP);

	always_ff @(posedge clk) begin
		if (adv.s3) begin
			d0_s3       <= d0;
			d1_s3       <= d1;
			d2_s3       <= d2;
			q0_s3       <= qp0[32 +: tfs_pkg::QUOT_W];
			q1_s3       <= qp1[32 +: tfs_pkg::QUOT_W];
			q2_s3       <= qp2[32 +: tfs_pkg::QUOT_W];
			band_hit_s3 <= band_hit_s2;
			band_idx_s3 <= band_idx_s2;
		end
	end

	// Stage 4: residues of the estimates, below twice the step
	logic [32:0]                qd0, qd1, qd2;
	logic [31:0]                rd0, rd1, rd2;
	logic [tfs_pkg::RES_W-1:0]  r0_s4, r1_s4, r2_s4;
	logic [tfs_pkg::QUOT_W-1:0] q0_s4, q1_s4;
	logic                           band_hit_s4;
	logic [tfs_pkg::BAND_IDX_W-1:0] band_idx_s4;

	assign qd0 = 33'(q0_s3) * 33'(tfs_pkg::GRID0_STEP);
	assign qd1 = 33'(q1_s3) * 33'(tfs_pkg::GRID12_STEP);
	assign qd2 = 33'(q2_s3) * 33'(tfs_pkg::GRID12_STEP);
	assign rd0 = d0_s3 - qd0[31:0];
	assign rd1 = d1_s3 - qd1[31:0];
	assign rd2 = d2_s3 - qd2[31:0];

	always_ff @(posedge clk) begin
		if (adv.s4) begin
			r0_s4       <= rd0[tfs_pkg::RES_W-1:0];
			r1_s4       <= rd1[tfs_pkg::RES_W-1:0];
			r2_s4       <= rd2[tfs_pkg::RES_W-1:0];
			q0_s4       <= q0_s3;
			q1_s4       <= q1_s3;
			band_hit_s4 <= band_hit_s3;
			band_idx_s4 <= band_idx_s3;
		end
	end

	// Stage 5: correct the estimates and keep the best grid
	logic [tfs_pkg::RES_W-1:0]  step0, step12;
	logic [tfs_pkg::RES_W-1:0]  r0c, r1c, r2c, r01;
	logic [tfs_pkg::QUOT_W-1:0] q0c, q1c;
	tfs_pkg::fit_t              fit_d;
	tfs_pkg::fit_t              fit_s5;

	assign step0  = 13'(tfs_pkg::GRID0_STEP);
	assign step12 = 13'(tfs_pkg::GRID12_STEP);

	always_comb begin
		r0c = r0_s4;
		q0c = q0_s4;
		if (r0_s4 >= step0) begin
			r0c = r0_s4 - step0;
			q0c = q0_s4 + 21'd1;
		end
		r1c = r1_s4;
		q1c = q1_s4;
		if (r1_s4 >= step12) begin
			r1c = r1_s4 - step12;
			q1c = q1_s4 + 21'd1;
		end
		r2c = (r2_s4 >= step12) ? (r2_s4 - step12) : r2_s4;
		r01 = (r1c <= r0c) ? r1c : r0c;

		fit_d.band_hit = band_hit_s4;
		fit_d.band_idx = band_idx_s4;
		fit_d.invalid  = 1'b1;
		fit_d.ch       = '0;
		if (r2c < r01) begin
			// third grid always lands at channel 24 or above
			fit_d.invalid = 1'b1;
		end else if (r1c <= r0c) begin
			if (q1c < tfs_pkg::GRID1_CH_LIMIT) begin
				fit_d.invalid = 1'b0;
				fit_d.ch      = q1c[tfs_pkg::CH_W-1:0] + tfs_pkg::GRID1_CH_OFFSET;
			end
		end else if (q0c < tfs_pkg::NUM_CH) begin
			fit_d.invalid = 1'b0;
			fit_d.ch      = q0c[tfs_pkg::CH_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s5) begin
			fit_s5 <= fit_d;
		end
	end

	assign fit = fit_s5;

endmodule

### rtl/tfs_reg_merge.sv
// Stage 6: synthesizer table lookup and merge with the kept prior bits into
// the result register. Depends on tfs_pkg.
module tfs_reg_merge (
	input  logic                              clk,
	input  logic                              load,
	input  tfs_pkg::fit_t                     fit,
	input  tfs_pkg::prior_t                   prior,
	output logic [tfs_pkg::OUT_DATA_W-1:0]    tdata,
	output logic [tfs_pkg::OUT_USER_W-1:0]    tuser
);

	logic [tfs_pkg::FRAC_W-1:0] frac;
	logic [3:0]                 bbits;
	logic [tfs_pkg::CH_W-1:0]   ch;
	logic                       band_hit;
	logic [tfs_pkg::REG_W-1:0]  band_reg, divider_reg, swallow_reg;
	logic [tfs_pkg::REG_W-1:0]  frac_high_reg, frac_mid_reg, frac_low_reg;
	logic [tfs_pkg::OUT_DATA_W-1:0] tdata_s6;
	logic [tfs_pkg::OUT_USER_W-1:0] tuser_s6;

	assign frac  = tfs_pkg::syn_frac(fit.ch);
	assign bbits = tfs_pkg::band_bits(fit.band_idx);

	// Merge table values into the kept bits; hold priors on an invalid channel
	always_comb begin
		if (fit.invalid) begin
			ch            = '0;
			band_hit      = 1'b0;
			band_reg      = prior.band;
			divider_reg   = prior.divider;
			swallow_reg   = prior.swallow;
			frac_high_reg = prior.frac_high;
			frac_mid_reg  = '0;
			frac_low_reg  = '0;
		end else begin
			ch            = fit.ch;
			band_hit      = fit.band_hit;
			band_reg      = fit.band_hit ?
			                ((prior.band & tfs_pkg::KEEP_BAND) | {bbits, 4'd0}) :
			                prior.band;
			divider_reg   = (prior.divider & tfs_pkg::KEEP_DIVIDER) |
			                8'(tfs_pkg::syn_n(fit.ch));
			swallow_reg   = (prior.swallow & tfs_pkg::KEEP_SWALLOW) |
			                8'(tfs_pkg::syn_a(fit.ch));
			frac_high_reg = (prior.frac_high & tfs_pkg::KEEP_FRAC_HIGH) |
			                8'(frac[21:16]);
			frac_mid_reg  = frac[15:8];
			frac_low_reg  = frac[7:0];
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			tdata_s6 <= {3'd0, frac_low_reg, frac_mid_reg, frac_high_reg,
			             swallow_reg, divider_reg, band_reg, ch};
			tuser_s6 <= {band_hit, fit.invalid};
		end
	end

	assign tdata = tdata_s6;
	assign tuser = tuser_s6;

endmodule

### rtl/tuner_frequency_to_synth_settings.sv
// Tuner frequency to synthesizer register settings, top level.
// Each accepted input transaction passes through the six stages to its result on m_tvalid.
// Throughput: one transaction per cycle while m_tready is high; the pipeline, with a valid
// bit per stage, fills bubbles, so s_tready stays high while any stage is empty.
// Reset (arst_n low, asynchronous) empties the pipeline and restores register defaults.
// Depends on tfs_pkg, tfs_cfg_regs, tfs_channel_fit and tfs_reg_merge.
module tuner_frequency_to_synth_settings (
	input  logic                                clk,
	input  logic                                arst_n,
	// input stream
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [tfs_pkg::IN_DATA_W-1:0]       s_tdata,  // [31:0] frequency_khz
	// result stream
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [4:0] channel_index, [12:5] band_reg, [20:13] divider_reg,
	// [28:21] swallow_reg, [36:29] frac_high_reg, [44:37] frac_mid_reg,
	// [52:45] frac_low_reg, [55:53] zero
	output logic [tfs_pkg::OUT_DATA_W-1:0]      m_tdata,
	output logic [tfs_pkg::OUT_USER_W-1:0]      m_tuser,  // [0] channel_invalid, [1] band_hit
	// configuration
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [tfs_pkg::ADDR_W-1:0]          paddr,
	input  logic [tfs_pkg::APB_DATA_W-1:0]      pwdata,
	output logic [tfs_pkg::APB_DATA_W-1:0]      prdata,
	output logic                                pready
);

	localparam int unsigned LAST = tfs_pkg::NUM_STAGES - 1;

	logic [tfs_pkg::NUM_STAGES-1:0] valid_q;
	logic [tfs_pkg::NUM_STAGES-1:0] ready;
	tfs_pkg::adv_t                  adv;
	tfs_pkg::prior_t                prior;
	tfs_pkg::fit_t                  fit;

	// Load a stage when it is empty or its content moves on
	always_comb begin
		ready[LAST] = !valid_q[LAST] || m_tready;
		for (int k = LAST - 1; k >= 0; k--) begin
			ready[k] = !valid_q[k] || ready[k+1];
		end
	end

	assign adv.s1 = ready[0];
	assign adv.s2 = ready[1];
	assign adv.s3 = ready[2];
	assign adv.s4 = ready[3];
	assign adv.s5 = ready[4];
	assign adv.s6 = ready[5];

	// Advance the valid bits along the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else begin
			if (ready[0]) begin
				valid_q[0] <= s_tvalid;
			end
			for (int k = 1; k < tfs_pkg::NUM_STAGES; k++) begin
				if (ready[k]) begin
					valid_q[k] <= valid_q[k-1];
				end
			end
		end
	end

	assign s_tready = ready[0];
	assign m_tvalid = valid_q[LAST];

	tfs_cfg_regs u_cfg_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.prior   (prior)
	);

	tfs_channel_fit u_channel_fit (
		.clk           (clk),
		.adv           (adv),
		.frequency_khz (s_tdata),
		.fit           (fit)
	);

	tfs_reg_merge u_reg_merge (
		.clk   (clk),
		.load  (adv.s6),
		.fit   (fit),
		.prior (prior),
		.tdata (m_tdata),
		.tuser (m_tuser)
	);

endmodule

### rtl/tfs_checker.sv
// Port-level checker for the tuner synthesizer block, bound to the top level.
// Depends on tuner_frequency_to_synth_settings_assert.svh and tfs_pkg.
`include "tuner_frequency_to_synth_settings_assert.svh"

module tfs_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               m_tvalid,
	input  logic                               m_tready,
	input  logic [tfs_pkg::OUT_DATA_W-1:0]     m_tdata,
	input  logic [tfs_pkg::OUT_USER_W-1:0]     m_tuser
);

	// A stalled result stays offered
	`TFS_ASSERT_NEXT(a_stall_holds, clk, arst_n, m_tvalid && !m_tready, m_tvalid)

	// An invalid channel reports index zero and no band hit
	`TFS_ASSERT_IMPLY(a_invalid_clean, clk, arst_n, m_tvalid && m_tuser[0], m_tdata[4:0] == 5'd0 && !m_tuser[1])

	// An invalid channel clears the low fraction registers
	`TFS_ASSERT_IMPLY(a_invalid_frac, clk, arst_n, m_tvalid && m_tuser[0], m_tdata[52:37] == 16'd0)

	// A valid channel lies inside the table
	`TFS_ASSERT_IMPLY(a_valid_range, clk, arst_n, m_tvalid && !m_tuser[0], m_tdata[4:0] < 5'd24)

endmodule

bind tuner_frequency_to_synth_settings tfs_checker u_tfs_checker (.*);

### tb/tfs_settings_checker.sv
// Checker for the tuner synthesizer settings block: watches the input, result and
// register channels, predicts each result and compares it field by field.
// Depends on tfs_pkg for the register index and reset values.
module tfs_settings_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] frequency_khz
	input  logic        m_tvalid,
	input  logic        m_tready,
	// [4:0] channel_index, [12:5] band_reg, [20:13] divider_reg, [28:21] swallow_reg,
	// [36:29] frac_high_reg, [44:37] frac_mid_reg, [52:45] frac_low_reg, [55:53] zero
	input  logic [55:0] m_tdata,
	input  logic [1:0]  m_tuser,   // [0] channel_invalid, [1] band_hit
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic [31:0] prdata,
	input  logic        pready,
	output int          failures,
	output int          outstanding
);

	localparam bit [31:0] GRID0_ORIGIN = 32'd104948;
	localparam bit [31:0] GRID0_PITCH  = 32'd3836;
	localparam bit [31:0] GRID1_ORIGIN = 32'd161300;
	localparam bit [31:0] GRID2_ORIGIN = 32'd159300;
	localparam bit [31:0] GRID12_PITCH = 32'd4000;
	localparam bit [31:0] CHANNEL_COUNT = 32'd24;
	localparam bit [31:0] BAND_OFFSET  = 32'd500;

	typedef struct packed {
		logic [4:0] channel_index;
		logic       channel_invalid;
		logic       band_hit;
		logic [7:0] band_reg;
		logic [7:0] divider_reg;
		logic [7:0] swallow_reg;
		logic [7:0] frac_high_reg;
		logic [7:0] frac_mid_reg;
		logic [7:0] frac_low_reg;
	} synth_settings_t;

	bit [7:0] band_prior;
	bit [7:0] divider_prior;
	bit [7:0] swallow_prior;
	bit [7:0] frac_high_prior;

	synth_settings_t pending_settings[$];
	synth_settings_t seen;
	synth_settings_t want;
	bit [7:0]        reg_now;

	// Fit the frequency to the three grids; 24 and above means no valid channel
	function automatic bit [31:0] fit_channel(input bit [31:0] khz);
		bit [31:0] f, q0, q1, q2, r0, r1, r2, best;
		f = khz / 32'd10;
		q0 = (f - GRID0_ORIGIN) / GRID0_PITCH;
		r0 = f - (GRID0_ORIGIN + GRID0_PITCH * q0);
		q1 = (f - GRID1_ORIGIN) / GRID12_PITCH;
		r1 = f - (GRID1_ORIGIN + GRID12_PITCH * q1);
		q2 = (f - GRID2_ORIGIN) / GRID12_PITCH;
		r2 = f - (GRID2_ORIGIN + GRID12_PITCH * q2);
		best = (r0 < r1) ? r0 : r1;
		if (r2 < best)
			return q2 + CHANNEL_COUNT;
		if (best == r1)
			return q1 + 32'd12;
		return q0;
	endfunction

	// Band range edges, highest first; range i spans [edge(i+1), edge(i))
	function automatic bit [31:0] band_edge(input int i);
		case (i)
			0:       return 32'd2151000;
			1:       return 32'd1950000;
			2:       return 32'd1800000;
			3:       return 32'd1600000;
			4:       return 32'd1450000;
			5:       return 32'd1250000;
			6:       return 32'd1200000;
			7:       return 32'd975000;
			default: return 32'd950000;
		endcase
	endfunction

	// Synthesizer table per channel: {N, A, fraction}
	function automatic bit [30:0] synth_entry(input bit [4:0] ch);
		case (ch)
			5'd0:    return {5'h0d, 4'h5, 22'h38fae1};
			5'd1:    return {5'h0e, 4'h3, 22'h3f570a};
			5'd2:    return {5'h0e, 4'h5, 22'h05b333};
			5'd3:    return {5'h0f, 4'h4, 22'h3c0f5c};
			5'd4:    return {5'h0f, 4'h6, 22'h026b85};
			5'd5:    return {5'h10, 4'h5, 22'h38c7ae};
			5'd6:    return {5'h11, 4'h3, 22'h3f23d7};
			5'd7:    return {5'h11, 4'h5, 22'h058000};
			5'd8:    return {5'h12, 4'h4, 22'h3bdc28};
			5'd9:    return {5'h12, 4'h6, 22'h023851};
			5'd10:   return {5'h13, 4'h5, 22'h38947a};
			5'd11:   return {5'h14, 4'h3, 22'h3ef0a3};
			5'd12:   return {5'h16, 4'h4, 22'h3c8000};
			5'd13:   return {5'h16, 4'h6, 22'h048000};
			5'd14:   return {5'h17, 4'h5, 22'h3c8000};
			5'd15:   return {5'h18, 4'h3, 22'h048000};
			5'd16:   return {5'h18, 4'h6, 22'h3c8000};
			5'd17:   return {5'h19, 4'h4, 22'h048000};
			5'd18:   return {5'h1a, 4'h3, 22'h3c8000};
			5'd19:   return {5'h1a, 4'h5, 22'h048000};
			5'd20:   return {5'h1b, 4'h4, 22'h3c8000};
			5'd21:   return {5'h1b, 4'h6, 22'h048000};
			5'd22:   return {5'h1c, 4'h5, 22'h3c8000};
			default: return {5'h1d, 4'h3, 22'h048000};
		endcase
	endfunction

	// Work out the register settings for one requested frequency
	function automatic synth_settings_t predict_settings(input bit [31:0] khz);
		synth_settings_t r;
		bit [31:0]       ch;
		bit [31:0]       x;
		bit [30:0]       entry;
		bit [2:0]        sel;
		ch = fit_channel(khz);
		x = khz - BAND_OFFSET;
		r = '0;
		r.band_reg = band_prior;
		r.divider_reg = divider_prior;
		r.swallow_reg = swallow_prior;
		r.frac_high_reg = frac_high_prior;
		if (ch >= CHANNEL_COUNT) begin
			r.channel_invalid = 1'b1;
			return r;
		end
		for (int i = 0; i < 8; i++) begin
			if (band_edge(i + 1) <= x && x < band_edge(i)) begin
				sel = (i < 6) ? 3'(7 - i) : 3'(13 - i);
				r.band_hit = 1'b1;
				r.band_reg = {i < 6, sel, band_prior[3:0]};
			end
		end
		entry = synth_entry(ch[4:0]);
		r.channel_index = ch[4:0];
		r.divider_reg = (divider_prior & 8'h40) | {3'b000, entry[30:26]};
		r.swallow_reg = {swallow_prior[7:4], entry[25:22]};
		r.frac_high_reg = {frac_high_prior[7:6], entry[21:16]};
		r.frac_mid_reg = entry[15:8];
		r.frac_low_reg = entry[7:0];
		return r;
	endfunction

	function void check_field(input string field, input logic [31:0] exp_v, act_v);
		if (act_v !== exp_v) begin
			$error("%s: expected 0x%0h, actual 0x%0h", field, exp_v, act_v);
			failures++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			band_prior = tfs_pkg::RST_BAND;
			divider_prior = tfs_pkg::RST_DIVIDER;
			swallow_prior = tfs_pkg::RST_SWALLOW;
			frac_high_prior = tfs_pkg::RST_FRAC_HIGH;
			pending_settings.delete();
			failures = 0;
			outstanding = 0;
		end else begin
			// Retire the oldest expectation against each result transaction
			if (m_tvalid && m_tready) begin
				seen = '0;
				seen.channel_index = m_tdata[4:0];
				seen.band_reg = m_tdata[12:5];
				seen.divider_reg = m_tdata[20:13];
				seen.swallow_reg = m_tdata[28:21];
				seen.frac_high_reg = m_tdata[36:29];
				seen.frac_mid_reg = m_tdata[44:37];
				seen.frac_low_reg = m_tdata[52:45];
				seen.channel_invalid = m_tuser[0];
				seen.band_hit = m_tuser[1];
				if (pending_settings.size() == 0) begin
					$error("result transaction with nothing outstanding: tdata 0x%0h tuser 0x%0h",
						m_tdata, m_tuser);
					failures++;
				end else begin
					want = pending_settings.pop_front();
					check_field("channel_index", want.channel_index, seen.channel_index);
					check_field("channel_invalid", want.channel_invalid, seen.channel_invalid);
					check_field("band_hit", want.band_hit, seen.band_hit);
					check_field("band_reg", want.band_reg, seen.band_reg);
					check_field("divider_reg", want.divider_reg, seen.divider_reg);
					check_field("swallow_reg", want.swallow_reg, seen.swallow_reg);
					check_field("frac_high_reg", want.frac_high_reg, seen.frac_high_reg);
					check_field("frac_mid_reg", want.frac_mid_reg, seen.frac_mid_reg);
					check_field("frac_low_reg", want.frac_low_reg, seen.frac_low_reg);
				end
			end

			// Predict each accepted request with the registers as they stand
			if (s_tvalid && s_tready)
				pending_settings.push_back(predict_settings(s_tdata));

			// Track register writes and check read data
			if (psel && penable && pready) begin
				reg_now = '0;
				case (tfs_pkg::reg_idx_t'(paddr[3:2]))
					tfs_pkg::REG_BAND_PRIOR: begin
						if (pwrite) band_prior = pwdata[7:0];
						reg_now = band_prior;
					end
					tfs_pkg::REG_DIVIDER_PRIOR: begin
						if (pwrite) divider_prior = pwdata[7:0];
						reg_now = divider_prior;
					end
					tfs_pkg::REG_SWALLOW_PRIOR: begin
						if (pwrite) swallow_prior = pwdata[7:0];
						reg_now = swallow_prior;
					end
					default: begin
						if (pwrite) frac_high_prior = pwdata[7:0];
						reg_now = frac_high_prior;
					end
				endcase
				if (!pwrite)
					check_field("prdata", {24'd0, reg_now}, prdata);
			end
			outstanding = pending_settings.size();
		end
	end

endmodule

### tb/tb.sv
// Top of the tuner synthesizer settings testbench: clock, reset, register setup,
// request stimulus with random gaps and result back-pressure, and the verdict.
// Depends on tfs_pkg, tfs_settings_checker and the block under test.
module tb;

	localparam int ITEMS_PER_PHASE = 80;
	localparam int PHASES          = 6;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // [31:0] frequency_khz
	logic        m_tvalid;
	logic        m_tready;
	// [4:0] channel_index, [12:5] band_reg, [20:13] divider_reg, [28:21] swallow_reg,
	// [36:29] frac_high_reg, [44:37] frac_mid_reg, [52:45] frac_low_reg, [55:53] zero
	logic [55:0] m_tdata;
	logic [1:0]  m_tuser;   // [0] channel_invalid, [1] band_hit
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	int          failures;
	int          outstanding;
	bit          quiet;

	// Grid centers, band edges, wrap corners, a grid tie and a third-grid win
	bit [31:0] corner_freqs [24] = '{
		32'd0, 32'hffffffff, 32'd499, 32'd500, 32'd501,
		32'd1049480, 32'd1049489, 32'd1471440, 32'd1613000, 32'd2053000,
		32'd2092999, 32'd1593000, 32'd25293000, 32'd1250500, 32'd1250499,
		32'd1950500, 32'd1950499, 32'd950500, 32'd2151499, 32'd2151500,
		32'd1200500, 32'd975499, 32'h80000000, 32'h7fffffff
	};

	tuner_frequency_to_synth_settings i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	tfs_settings_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.failures    (failures),
		.outstanding (outstanding)
	);

	always #5 clk = ~clk;

	// One register transfer: setup cycle, access cycle, then bus idle
	task automatic reg_access(input bit wr, input tfs_pkg::reg_idx_t idx,
		input bit [7:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= {idx, 2'b00};
		pwdata <= {24'($urandom_range(0, 32'h00ffffff)), value};
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic program_priors(input bit [7:0] band, divider, swallow, frac_high);
		reg_access(1'b1, tfs_pkg::REG_BAND_PRIOR, band);
		reg_access(1'b1, tfs_pkg::REG_DIVIDER_PRIOR, divider);
		reg_access(1'b1, tfs_pkg::REG_SWALLOW_PRIOR, swallow);
		reg_access(1'b1, tfs_pkg::REG_FRAC_HIGH_PRIOR, frac_high);
		reg_access(1'b0, tfs_pkg::REG_BAND_PRIOR, 8'd0);
		reg_access(1'b0, tfs_pkg::REG_DIVIDER_PRIOR, 8'd0);
		reg_access(1'b0, tfs_pkg::REG_SWALLOW_PRIOR, 8'd0);
		reg_access(1'b0, tfs_pkg::REG_FRAC_HIGH_PRIOR, 8'd0);
	endtask

	// Offer one request, with an optional idle burst ahead of it
	task automatic send_frequency(input bit [31:0] khz);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= khz;
		do
			@(posedge clk);
		while (!s_tready);
		@(negedge clk);
	endtask

	// Hold off requests until every expected result has come back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (outstanding != 0)
			@(negedge clk);
	endtask

	// Mostly valid tuning range and grid points, plus band edges and raw noise
	function automatic bit [31:0] random_frequency();
		int unsigned pick;
		bit [31:0]   ch;
		bit [31:0]   f;
		pick = $urandom_range(0, 99);
		if (pick < 50) begin
			if ($urandom_range(0, 1))
				return $urandom_range(1049480, 1509799);
			return $urandom_range(1613000, 2092999);
		end
		if (pick < 70) begin
			ch = $urandom_range(0, 23);
			f = (ch < 12) ? 32'd104948 + 32'd3836 * ch : 32'd161300 + 32'd4000 * (ch - 12);
			f = f + $urandom_range(0, 40) - 20;
			return f * 32'd10 + $urandom_range(0, 9);
		end
		if (pick < 80) begin
			case ($urandom_range(0, 8))
				0:       f = 32'd2151000;
				1:       f = 32'd1950000;
				2:       f = 32'd1800000;
				3:       f = 32'd1600000;
				4:       f = 32'd1450000;
				5:       f = 32'd1250000;
				6:       f = 32'd1200000;
				7:       f = 32'd975000;
				default: f = 32'd950000;
			endcase
			return f + 32'd500 + $urandom_range(0, 6) - 3;
		end
		if (pick < 92)
			return $urandom;
		if ($urandom_range(0, 1))
			return $urandom_range(0, 1000);
		return 32'hffffffff - $urandom_range(0, 1000);
	endfunction

	// Result back-pressure in random bursts, none once the run goes quiet
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if (!quiet && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(negedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(negedge clk);
		end
	end

	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		quiet = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset values, then the corner requests under them
		reg_access(1'b0, tfs_pkg::REG_BAND_PRIOR, 8'd0);
		reg_access(1'b0, tfs_pkg::REG_DIVIDER_PRIOR, 8'd0);
		reg_access(1'b0, tfs_pkg::REG_SWALLOW_PRIOR, 8'd0);
		reg_access(1'b0, tfs_pkg::REG_FRAC_HIGH_PRIOR, 8'd0);
		foreach (corner_freqs[i])
			send_frequency(corner_freqs[i]);
		drain_results();

		// Random phases: all clear, all set, then random register settings
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0:       program_priors(8'h00, 8'h00, 8'h00, 8'h00);
				1:       program_priors(8'hff, 8'hff, 8'hff, 8'hff);
				default: program_priors(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
			endcase
			quiet = (phase == PHASES - 1);
			repeat (ITEMS_PER_PHASE)
				send_frequency(random_frequency());
			drain_results();
		end

		repeat (20) @(negedge clk);
		if (failures == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

### tuner_frequency_to_synth_settings.f
+incdir+rtl
rtl/tfs_pkg.sv
rtl/tfs_cfg_regs.sv
rtl/tfs_channel_fit.sv
rtl/tfs_reg_merge.sv
rtl/tuner_frequency_to_synth_settings.sv
rtl/tfs_checker.sv
tb/tfs_settings_checker.sv
tb/tb.sv
